// ===== rtl/wsh_pkg.sv =====
// wsh_pkg: shared constants, queue entry type and lookup3 helper functions
// for the word sequence hash block; used by every rtl file, depends on nothing
package wsh_pkg;

	localparam int unsigned LENGTH_BITS = 16;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

	localparam logic [31:0] INIT_CONST = 32'hdeadbeef;
	localparam logic [31:0] SEED_RESET = 32'd2016;

	localparam logic [1:0] SLOT_A = 2'd0;
	localparam logic [1:0] SLOT_B = 2'd1;
	localparam logic [1:0] SLOT_C = 2'd2;

	// one classified key word as handed from front to back
	typedef struct packed {
		logic [31:0] word;
		logic [31:0] init;
		logic        first;
		logic        empty;
		logic        last;
		logic [1:0]  slot;
	} wsh_op_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] r);
		rotl = (x << r) | (x >> (6'd32 - {1'b0, r}));
	endfunction

	// mix round half: x -= y; x ^= rotl(y, r)
	function automatic logic [31:0] mix_half(input logic [31:0] x, input logic [31:0] y,
		input logic [4:0] r);
		mix_half = (x - y) ^ rotl(y, r);
	endfunction

	// final avalanche step: x ^= y; x -= rotl(y, r)
	function automatic logic [31:0] fin_step(input logic [31:0] x, input logic [31:0] y,
		input logic [4:0] r);
		fin_step = (x ^ y) - rotl(y, r);
	endfunction

endpackage

// ===== rtl/wsh_front.sv =====
// wsh_front: takes key words, tracks key position and lane slot, holds the seed
// and builds one queue entry per request; depends on wsh_pkg
module wsh_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [31:0]          cfg_wdata,
	input  logic                 in_valid,
	input  logic [31:0]          key_word,
	input  logic [15:0]          key_length,
	input  logic                 q_full,
	output logic                 push,
	output wsh_pkg::wsh_op_t     push_op
);

	logic [31:0]                       seed_q;
	logic [wsh_pkg::LENGTH_BITS-1:0]   words_left_q;
	logic [1:0]                        slot_q;
	logic [wsh_pkg::LENGTH_BITS-1:0]   len;
	logic                              is_start;

	always_comb begin
		len              = key_length[wsh_pkg::LENGTH_BITS-1:0];
		is_start         = (words_left_q == '0);
		push             = in_valid && !q_full;
		push_op.word     = key_word;
		push_op.init     = wsh_pkg::INIT_CONST + (32'(len) << 2) + seed_q;
		push_op.first    = is_start;
		push_op.empty    = is_start && (len == '0);
		push_op.slot     = is_start ? wsh_pkg::SLOT_A : slot_q;
		push_op.last     = is_start ? (len == wsh_pkg::LENGTH_BITS'(1))
			: (words_left_q == wsh_pkg::LENGTH_BITS'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q       <= wsh_pkg::SEED_RESET;
			words_left_q <= '0;
			slot_q       <= wsh_pkg::SLOT_A;
		end else begin
			if (cfg_we) begin
				seed_q <= cfg_wdata;
			end
			if (push && !push_op.empty) begin
				words_left_q <= (is_start ? len : words_left_q) - wsh_pkg::LENGTH_BITS'(1);
				if (push_op.last || push_op.slot == wsh_pkg::SLOT_C) begin
					slot_q <= wsh_pkg::SLOT_A;
				end else begin
					slot_q <= push_op.slot + 2'd1;
				end
			end
		end
	end

endmodule

// ===== rtl/wsh_queue.sv =====
// wsh_queue: short register queue of classified key words between front and
// back; depends on wsh_pkg
module wsh_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  wsh_pkg::wsh_op_t     push_op,
	input  logic                 pop,
	output logic                 full,
	output logic                 head_valid,
	output wsh_pkg::wsh_op_t     head_op
);

	wsh_pkg::wsh_op_t                entry_q [wsh_pkg::QUEUE_DEPTH];
	logic [wsh_pkg::QUEUE_AW-1:0]    wr_ptr_q;
	logic [wsh_pkg::QUEUE_AW-1:0]    rd_ptr_q;
	logic [wsh_pkg::QUEUE_AW:0]      count_q;

	assign full       = (count_q == (wsh_pkg::QUEUE_AW+1)'(wsh_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_op    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/wsh_back.sv =====
// wsh_back: lane registers, word add, mix and final sequencer and result
// register; depends on wsh_pkg
module wsh_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  wsh_pkg::wsh_op_t     head_op,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [31:0]          hash_value
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_MIX  = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t       state_q;
	logic [1:0]   cnt_q;
	logic [31:0]  a_q, b_q, c_q;
	logic [31:0]  hash_q;
	logic         out_valid_q;
	logic         out_free;
	logic [31:0]  add_a, add_b, add_c;
	logic [31:0]  ta, tb, tc;

	assign out_free   = !out_valid_q || !out_stall;
	assign out_valid  = out_valid_q;
	assign hash_value = hash_q;
	assign pop        = (state_q == ST_IDLE) && head_valid && (!head_op.empty || out_free);

	// word add into the selected lane
	always_comb begin
		add_a = head_op.first ? head_op.init : a_q;
		add_b = head_op.first ? head_op.init : b_q;
		add_c = head_op.first ? head_op.init : c_q;
		case (head_op.slot)
			wsh_pkg::SLOT_A: add_a = add_a + head_op.word;
			wsh_pkg::SLOT_B: add_b = add_b + head_op.word;
			default:         add_c = add_c + head_op.word;
		endcase
	end

	// two mix steps or up to two final steps a cycle
	always_comb begin
		ta = a_q;
		tb = b_q;
		tc = c_q;
		if (state_q == ST_MIX) begin
			case (cnt_q)
				2'd0: begin
					ta = wsh_pkg::mix_half(a_q, c_q, 5'd4);
					tc = c_q + b_q;
					tb = wsh_pkg::mix_half(b_q, ta, 5'd6);
					ta = ta + tc;
				end
				2'd1: begin
					tc = wsh_pkg::mix_half(c_q, b_q, 5'd8);
					tb = b_q + a_q;
					ta = wsh_pkg::mix_half(a_q, tc, 5'd16);
					tc = tc + tb;
				end
				default: begin
					tb = wsh_pkg::mix_half(b_q, a_q, 5'd19);
					ta = a_q + c_q;
					tc = wsh_pkg::mix_half(c_q, tb, 5'd4);
					tb = tb + ta;
				end
			endcase
		end else begin
			case (cnt_q)
				2'd0: begin
					tc = wsh_pkg::fin_step(c_q, b_q, 5'd14);
					ta = wsh_pkg::fin_step(a_q, tc, 5'd11);
				end
				2'd1: begin
					tb = wsh_pkg::fin_step(b_q, a_q, 5'd25);
					tc = wsh_pkg::fin_step(c_q, tb, 5'd16);
				end
				2'd2: begin
					ta = wsh_pkg::fin_step(a_q, c_q, 5'd4);
					tb = wsh_pkg::fin_step(b_q, ta, 5'd14);
				end
				default: begin
					tc = wsh_pkg::fin_step(c_q, b_q, 5'd24);
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop && !head_op.empty) begin
					a_q <= add_a;
					b_q <= add_b;
					c_q <= add_c;
				end
				if (pop && head_op.empty) begin
					hash_q <= head_op.init;
				end
			end
			ST_MIX: begin
				a_q <= ta;
				b_q <= tb;
				c_q <= tc;
			end
			ST_FIN: begin
				if (cnt_q != 2'd3) begin
					a_q <= ta;
					b_q <= tb;
					c_q <= tc;
				end else if (out_free) begin
					hash_q <= tc;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					cnt_q <= 2'd0;
					if (pop) begin
						if (head_op.empty) begin
							out_valid_q <= 1'b1;
						end else if (head_op.last) begin
							state_q <= ST_FIN;
						end else if (head_op.slot == wsh_pkg::SLOT_C) begin
							state_q <= ST_MIX;
						end
					end
				end
				ST_MIX: begin
					if (cnt_q == 2'd2) begin
						cnt_q   <= 2'd0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 2'd1;
					end
				end
				ST_FIN: begin
					if (cnt_q != 2'd3) begin
						cnt_q <= cnt_q + 2'd1;
					end else if (out_free) begin
						out_valid_q <= 1'b1;
						cnt_q       <= 2'd0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/word_sequence_hash.sv =====
// word_sequence_hash: top level of the lookup3 hashword block over 32-bit words
// depends on wsh_pkg, wsh_front, wsh_queue and wsh_back
//
// A key is sent as one request per 32-bit word; the first request of a key also
// carries its length, and a zero length returns the initial value with no mixing.
// The hash comes out once, after the last word. Words are taken back to back, while
// the queue is not full, into a four-entry queue; the back end adds each word into
// its lane, runs the mix after each full group of three that is followed by more
// words and the final avalanche after the last word, and takes no word from the
// queue meanwhile. The seed is written through cfg_we and cfg_wdata between keys;
// the user must keep to this, as the block itself does not enforce it.
module word_sequence_hash (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [31:0]  cfg_wdata,
	input  logic         in_valid,
	output logic         in_stall,
	input  logic [31:0]  key_word,
	input  logic [15:0]  key_length,
	output logic         out_valid,
	input  logic         out_stall,
	output logic [31:0]  hash_value
);

	logic              push;
	logic              pop;
	logic              q_full;
	logic              head_valid;
	wsh_pkg::wsh_op_t  push_op;
	wsh_pkg::wsh_op_t  head_op;

	assign in_stall = q_full;

	wsh_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.key_word   (key_word),
		.key_length (key_length),
		.q_full     (q_full),
		.push       (push),
		.push_op    (push_op)
	);

	wsh_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_op    (push_op),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_op    (head_op)
	);

	wsh_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_op    (head_op),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hash_value (hash_value)
	);

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("back end took a word from an empty queue");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("front end wrote into a full queue");

	a_result_from_queue: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head_op.empty) |=> out_valid)
		else $error("empty key gave no result");

endmodule
